[hw/rtl/refcounted_sorted_key_table_macros.svh]
// Assertion macros for the sorted key table checker.
// No dependencies.
`ifndef REFCOUNTED_SORTED_KEY_TABLE_MACROS_SVH
`define REFCOUNTED_SORTED_KEY_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RSKT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
// Implication checked on every clock edge, reset included.
`define RSKT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");
`endif

[hw/rtl/rskt_pkg.sv]
// Shared types and constants for the sorted key table.
// No dependencies.
package rskt_pkg;
    localparam int Capacity = 256;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    // entry layout: key 64, version 63, handle 32, refs 32
    localparam int EntW = 64 + 63 + 32 + 32;

    localparam logic [1:0] KIND_GET = 2'd0;
    localparam logic [1:0] KIND_ADD = 2'd1;
    localparam logic [1:0] KIND_REL = 2'd2;
    localparam logic [1:0] KIND_CLR = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_REFERENCED = 3'd5;

    typedef struct packed {
        logic [63:0] key;
        logic [62:0] ver;
        logic [31:0] handle;
        logic [31:0] refs;
    } entry_t;
endpackage

[hw/rtl/refcounted_sorted_key_table.sv]
// Top level of the reference-counted sorted key table.
// Depends on rskt_pkg and rskt_ram.
//
// Usage: one item on the s_ channel (kind, table_key, key_version,
// new_handle) gives exactly one item on the m_ channel (status,
// found_handle, freed_valid, freed_handle). Items are handled one at a time:
// s_ready is high only while the sequencer is idle and no result waits.
// A clear or an invalid key goes straight to the result. Any other item
// runs one binary search over the stored entries, one probe at a time
// through the one RAM read port with its registered read data. An add or a
// removing release then moves every entry behind the position by one place,
// one entry at a time through the same read and write port.
// Reset clears the entry count and the sequencer; the RAM holds anything
// until written, and only entries below the count are ever used.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it has been accepted.
module refcounted_sorted_key_table
    import rskt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_table_key,
    input  logic signed [63:0] s_key_version,
    input  logic [31:0] s_new_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_found_handle,
    output logic        m_freed_valid,
    output logic [31:0] m_freed_handle
);
    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_DECIDE, S_HITRD, S_HITWR,
        S_UPRD, S_UPWR, S_DNRD, S_DNWR, S_INS, S_OUT
    } state_t;

    state_t state_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] lo_reg, hi_reg, ptr_reg;
    logic [1:0]  kind_reg;
    logic [63:0] key_reg;
    logic [62:0] ver_reg;
    logic [31:0] hdl_reg;
    logic [2:0]  status_reg;
    logic [31:0] found_reg, freed_reg;
    logic        freed_valid_reg;

    logic          wr_en;
    logic [IdxW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic [EntW-1:0] rd_raw;

    rskt_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_raw)
    );
    assign rd_data = entry_t'(rd_raw);

    // mid of the current search window
    logic [CntW-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // entry below the search key
    logic below;
    assign below = (rd_data.key < key_reg) ||
                   (rd_data.key == key_reg && rd_data.ver < ver_reg);

    logic hit;
    assign hit = (rd_data.key == key_reg) && (rd_data.ver == ver_reg);

    logic key_bad;
    assign key_bad = (s_table_key == '0) || (s_table_key == '1) || s_key_version[63];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_status = status_reg;
    assign m_found_handle = found_reg;
    assign m_freed_valid = freed_valid_reg;
    assign m_freed_handle = freed_reg;

    // RAM port steering
    always_comb begin
        rd_addr = ptr_reg[IdxW-1:0];
        wr_en = 1'b0;
        wr_addr = ptr_reg[IdxW-1:0];
        wr_data = rd_data;
        case (state_reg)
            S_PROBE: rd_addr = mid[IdxW-1:0];
            S_HITWR: begin
                wr_en = 1'b1;
                wr_data.refs = (kind_reg == KIND_GET)
                    ? ((rd_data.refs == '1) ? rd_data.refs : rd_data.refs + 32'd1)
                    : ((rd_data.refs == '0) ? rd_data.refs : rd_data.refs - 32'd1);
            end
            S_UPRD: rd_addr = ptr_reg[IdxW-1:0] - 1'b1;
            S_UPWR: wr_en = 1'b1;
            S_DNRD: rd_addr = ptr_reg[IdxW-1:0] + 1'b1;
            S_DNWR: wr_en = 1'b1;
            S_INS: begin
                wr_en = 1'b1;
                wr_data = '{key: key_reg, ver: ver_reg, handle: hdl_reg, refs: 32'd1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    kind_reg <= s_kind;
                    key_reg <= s_table_key;
                    ver_reg <= s_key_version[62:0];
                    hdl_reg <= s_new_handle;
                    lo_reg <= '0;
                    hi_reg <= count_reg;
                    found_reg <= '0;
                    freed_reg <= '0;
                    freed_valid_reg <= 1'b0;
                    status_reg <= ST_OK;
                    if (s_kind == KIND_CLR) begin
                        status_reg <= (count_reg != '0) ? ST_REFERENCED : ST_OK;
                        count_reg <= '0;
                        state_reg <= S_OUT;
                    end else if (key_bad || (s_kind == KIND_ADD && s_new_handle == '0)) begin
                        status_reg <= ST_INVALID;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // window empty: lo is the lower bound; read it
                    if (lo_reg >= hi_reg) begin
                        ptr_reg <= lo_reg;
                        state_reg <= S_DECIDE;
                    end else begin
                        ptr_reg <= mid;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (below) lo_reg <= ptr_reg + 1'b1;
                    else hi_reg <= ptr_reg;
                    state_reg <= S_PROBE;
                end
                S_DECIDE: begin
                    // RAM data now holds entry at ptr (read issued in S_PROBE)
                    if (ptr_reg < count_reg && hit) begin
                        if (kind_reg == KIND_ADD) begin
                            status_reg <= ST_EXISTS;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_HITWR;
                        end
                    end else if (kind_reg == KIND_ADD) begin
                        if (count_reg >= CntW'(Capacity)) begin
                            status_reg <= ST_FULL;
                            state_reg <= S_OUT;
                        end else begin
                            lo_reg <= ptr_reg;
                            ptr_reg <= count_reg;
                            state_reg <= (count_reg > ptr_reg) ? S_UPRD : S_INS;
                        end
                    end else begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg <= S_OUT;
                    end
                end
                S_HITWR: begin
                    if (kind_reg == KIND_GET) begin
                        found_reg <= rd_data.handle;
                        state_reg <= S_OUT;
                    end else if (rd_data.refs <= 32'd1) begin
                        freed_valid_reg <= 1'b1;
                        freed_reg <= rd_data.handle;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= (ptr_reg + 1'b1 < count_reg) ? S_DNRD : S_OUT;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                // open a gap: entry[ptr] = entry[ptr-1], down to lo
                S_UPRD: state_reg <= S_UPWR;
                S_UPWR: begin
                    ptr_reg <= ptr_reg - 1'b1;
                    state_reg <= (ptr_reg - 1'b1 > lo_reg) ? S_UPRD : S_INS;
                end
                S_INS: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                // close the gap: entry[ptr] = entry[ptr+1]; count already lowered
                S_DNRD: state_reg <= S_DNWR;
                S_DNWR: begin
                    ptr_reg <= ptr_reg + 1'b1;
                    state_reg <= (ptr_reg + 1'b1 < count_reg) ? S_DNRD : S_OUT;
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[hw/rtl/rskt_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rskt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end
endmodule

[hw/rtl/rskt_checker.sv]
// Port-level checker for the sorted key table, bound to the top level.
// Depends on rskt_pkg and the assertion macros header.
`include "refcounted_sorted_key_table_macros.svh"
module rskt_checker
    import rskt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_found_handle,
    input logic        m_freed_valid,
    input logic [31:0] m_freed_handle
);
    `RSKT_ASSERT(a_one_at_a_time, aclk, aresetn, m_valid |-> !s_ready)
    `RSKT_ASSERT(a_found_only_ok, aclk, aresetn, (m_valid && m_found_handle != '0) |-> m_status == ST_OK)
    `RSKT_ASSERT(a_freed_only_ok, aclk, aresetn, (m_valid && m_freed_valid) |-> m_status == ST_OK)
    `RSKT_ASSERT(a_freed_zero, aclk, aresetn, (m_valid && !m_freed_valid) |-> m_freed_handle == '0)
    `RSKT_ASSERT(a_result_holds, aclk, aresetn, (m_valid && !m_ready) |=> m_valid && $stable(m_status))
endmodule

bind refcounted_sorted_key_table rskt_checker u_rskt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_found_handle(m_found_handle), .m_freed_valid(m_freed_valid),
    .m_freed_handle(m_freed_handle)
);

[tb/sv/refcounted_sorted_key_table_test.sv]
// Self-checking testbench for the reference-counted sorted key table.
// Depends on rskt_pkg and the refcounted_sorted_key_table RTL.
module refcounted_sorted_key_table_test;
    import rskt_pkg::*;

    // Table entry as the predictor holds it.
    typedef struct {
        logic [63:0] key;
        logic [62:0] ver;
        logic [31:0] handle;
        logic [31:0] refs;
    } tbl_entry_t;

    // One expected result item.
    typedef struct {
        logic [2:0]  status;
        logic [31:0] found_handle;
        logic        freed_valid;
        logic [31:0] freed_handle;
    } table_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_GET;
    logic [63:0] s_table_key = '0;
    logic signed [63:0] s_key_version = '0;
    logic [31:0] s_new_handle = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_found_handle;
    logic        m_freed_valid;
    logic [31:0] m_freed_handle;

    // Predictor state: sorted shadow of the table.
    tbl_entry_t   shadow_tbl[$];
    table_reply_t pending_replies[$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    // Keys added so far, reused by the random part so that hits are frequent.
    logic [63:0]  key_pool[$];
    logic [62:0]  ver_pool[$];

    refcounted_sorted_key_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_table_key    (s_table_key),
        .s_key_version  (s_key_version),
        .s_new_handle   (s_new_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found_handle (m_found_handle),
        .m_freed_valid  (m_freed_valid),
        .m_freed_handle (m_freed_handle)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Bound the run. Even with full-table shifts and heavy stalls on every item,
    // the limit leaves a wide margin.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 10000000) begin
            $display("[refcounted_sorted_key_table] ERROR");
            $finish;
        end
    end

    // Work out the reply to one item and advance the shadow table.
    function automatic table_reply_t predict_table_op(logic [1:0] kind, logic [63:0] key,
                                                      logic [63:0] ver_in, logic [31:0] hnd);
        table_reply_t r;
        logic [62:0]  ver;
        int           lo;
        int           hi;
        int           mid;
        bit           hit;
        tbl_entry_t   e;
        r = '{ST_OK, 32'd0, 1'b0, 32'd0};
        ver = ver_in[62:0];
        if (kind == KIND_CLR) begin
            r.status = (shadow_tbl.size() > 0) ? ST_REFERENCED : ST_OK;
            shadow_tbl.delete();
            return r;
        end
        if (key == 64'd0 || key == '1 || ver_in[63] || (kind == KIND_ADD && hnd == 32'd0)) begin
            r.status = ST_INVALID;
            return r;
        end
        // Lower bound over (key, version).
        lo = 0;
        hi = shadow_tbl.size();
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_tbl[mid].key < key ||
                (shadow_tbl[mid].key == key && shadow_tbl[mid].ver < ver))
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = lo < shadow_tbl.size() && shadow_tbl[lo].key == key && shadow_tbl[lo].ver == ver;
        case (kind)
            KIND_GET: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found_handle = shadow_tbl[lo].handle;
                    if (shadow_tbl[lo].refs != '1)
                        shadow_tbl[lo].refs++;
                end
            end
            KIND_ADD: begin
                if (hit) begin
                    r.status = ST_EXISTS;
                end else if (shadow_tbl.size() >= Capacity) begin
                    r.status = ST_FULL;
                end else begin
                    e = '{key, ver, hnd, 32'd1};
                    shadow_tbl.insert(lo, e);
                end
            end
            default: begin
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (shadow_tbl[lo].refs != 0)
                        shadow_tbl[lo].refs--;
                    if (shadow_tbl[lo].refs == 0) begin
                        r.freed_valid = 1'b1;
                        r.freed_handle = shadow_tbl[lo].handle;
                        shadow_tbl.delete(lo);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Hold the item until it is accepted, then record its expected reply.
    // Valid drops only while idling or draining, so items can follow back to back.
    task automatic send_table_op(logic [1:0] kind, logic [63:0] key, logic [63:0] ver,
                                 logic [31:0] hnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_table_key <= key;
        s_key_version <= ver;
        s_new_handle <= hnd;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_replies.push_back(predict_table_op(kind, key, ver, hnd));
        if (kind == KIND_ADD) begin
            key_pool.push_back(key);
            ver_pool.push_back(ver[62:0]);
        end
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random stall on the result side; compare each accepted reply.
    always @(posedge aclk) begin
        table_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: status %0d", m_status);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_found_handle !== want.found_handle) begin
                    $error("found_handle: expected %h, got %h", want.found_handle,
                           m_found_handle);
                    error_count++;
                end
                if (m_freed_valid !== want.freed_valid) begin
                    $error("freed_valid: expected %0d, got %0d", want.freed_valid,
                           m_freed_valid);
                    error_count++;
                end
                if (m_freed_handle !== want.freed_handle) begin
                    $error("freed_handle: expected %h, got %h", want.freed_handle,
                           m_freed_handle);
                    error_count++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Boundaries of every field and each special case.
    task automatic test_directed();
        send_table_op(KIND_CLR, '0, '0, '0);                    // clear on empty table
        send_table_op(KIND_GET, 64'd5, 64'sd1, '0);             // miss
        send_table_op(KIND_ADD, 64'd0, 64'sd1, 32'd1);          // key zero
        send_table_op(KIND_ADD, '1, 64'sd1, 32'd1);             // key all ones
        send_table_op(KIND_ADD, 64'd5, 64'h8000_0000_0000_0000, 32'd1); // negative version
        send_table_op(KIND_ADD, 64'd5, 64'sd1, 32'd0);          // null handle
        send_table_op(KIND_GET, 64'd0, 64'sd1, '0);
        send_table_op(KIND_REL, '1, 64'sd1, '0);
        send_table_op(KIND_ADD, 64'd5, 64'sd1, 32'hFFFF_FFFF);
        send_table_op(KIND_ADD, 64'd5, 64'h7FFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        send_table_op(KIND_ADD, 64'd1, 64'sd0, 32'd7);
        send_table_op(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 64'sd0, 32'hA5A5_5A5A);
        send_table_op(KIND_ADD, 64'd5, 64'sd1, 32'd9);          // duplicate key
        send_table_op(KIND_GET, 64'd5, 64'sd1, '0);             // hit, two refs
        send_table_op(KIND_REL, 64'd5, 64'sd1, '0);             // still referenced
        send_table_op(KIND_REL, 64'd5, 64'sd1, '0);             // removed
        send_table_op(KIND_REL, 64'd5, 64'sd1, '0);             // gone
        send_table_op(KIND_GET, 64'hFFFF_FFFF_FFFF_FFFE, 64'sd0, '0);
        send_table_op(KIND_GET, 64'd5, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_table_op(KIND_CLR, rand64(), rand64(), $urandom);  // clear with entries
        send_table_op(KIND_GET, 64'd1, 64'sd0, '0);
        drain_replies();
    endtask

    // Fill to capacity, then hit the full and duplicate-when-full cases.
    task automatic test_full_table();
        for (int i = 0; i < Capacity; i++)
            send_table_op(KIND_ADD, 64'd100 + (i * 37) % Capacity, {1'b0, 63'($urandom_range(3))},
                          32'd1 + i);
        send_table_op(KIND_ADD, key_pool[key_pool.size() - 1],
                      {1'b0, ver_pool[ver_pool.size() - 1]}, 32'd5);
        send_table_op(KIND_ADD, 64'd99, 64'sd0, 32'd5);
        drain_replies();
        send_table_op(KIND_CLR, '0, '0, '0);
        drain_replies();
    endtask

    // Mostly operations on known keys, with noise and wide random fields.
    task automatic test_random(int n);
        logic [63:0] key;
        logic [63:0] ver;
        int          pick;
        int unsigned sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (key_pool.size() > 0 && sel < 70) begin
                pick = $urandom_range(key_pool.size() - 1);
                key = key_pool[pick];
                ver = {1'b0, ver_pool[pick]};
            end else if (sel < 80) begin
                key = rand64();
                ver = rand64();
            end else begin
                key = 64'($urandom_range(8, 1));
                ver = 64'($urandom_range(3));
            end
            if (key_pool.size() > 300) begin
                key_pool.delete(0);
                ver_pool.delete(0);
            end
            sel = $urandom_range(99);
            if (sel < 1)
                send_table_op(KIND_CLR, rand64(), rand64(), $urandom);
            else if (sel < 35)
                send_table_op(KIND_ADD, key, ver, ($urandom_range(49) == 0) ? 32'd0 : $urandom);
            else if (sel < 65)
                send_table_op(KIND_GET, key, ver, $urandom);
            else
                send_table_op(KIND_REL, key, ver, $urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(400);
        // Hold off until the table has settled, then carry on.
        drain_replies();
        send_idle_pct = 71; recv_stall_pct = 0;  test_random(400);
        send_idle_pct = 0;  recv_stall_pct = 71; test_random(400);
        send_idle_pct = 37; recv_stall_pct = 37; test_random(400);
        drain_replies();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("[refcounted_sorted_key_table] OK");
        else
            $display("[refcounted_sorted_key_table] ERROR");
        $finish;
    end
endmodule

[refcounted_sorted_key_table.f]
+incdir+hw/rtl
hw/rtl/rskt_pkg.sv
hw/rtl/rskt_ram.sv
hw/rtl/refcounted_sorted_key_table.sv
hw/rtl/rskt_checker.sv
tb/sv/refcounted_sorted_key_table_test.sv
